[src/rrpr_pkg.sv]
// Shared types, constants and encoding functions of the raster row packer.
`default_nettype none

package rrpr_pkg;

  // Row store geometry.
  localparam int MAX_ROW_CELLS = 1024;
  localparam int ADDR_W        = $clog2(MAX_ROW_CELLS);
  localparam int CNT_W         = $clog2(MAX_ROW_CELLS + 1);
  localparam int CELL_W        = 32;

  // Encoding constants.
  localparam logic [7:0] RUN_LIMIT = 8'd255;
  localparam logic [7:0] SIGN_BIT  = 8'o200;
  localparam int         BYTE_BITS = 8;

  // Configuration register indexes.
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic p1_eval;
    logic p2_eval;
    logic decide;
    logic walk_start;
    logic walk_eval;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pending;
    logic comp;
    logic rle;
    logic hdr;
    logic pos_zero;
    logic closes_scan;
    logic scan_last;
    logic run_stop;
    logic slot_free;
  } sts_t;

  // Configured byte width clamped to 1..4.
  function automatic logic [2:0] eff_width(input logic [2:0] cw);
    logic [2:0] w;
    if (cw == 3'd0) w = 3'd1;
    else if (cw > 3'd4) w = 3'd4;
    else w = cw;
    return w;
  endfunction

  // Fewest bytes a cell needs; a negative cell needs all four.
  function automatic logic [2:0] sig_bytes(input logic [CELL_W-1:0] v);
    logic [2:0] n;
    if (v[31] || v[30:24] != 7'd0) n = 3'd4;
    else if (v[23:16] != 8'd0) n = 3'd3;
    else if (v[15:8] != 8'd0) n = 3'd2;
    else if (v[7:0] != 8'd0) n = 3'd1;
    else n = 3'd0;
    return n;
  endfunction

  // Sign-magnitude word of w bytes, sign in the top bit of the first byte.
  function automatic logic [CELL_W-1:0] enc_word(input logic [CELL_W-1:0] v,
                                                 input logic [2:0] w);
    logic [CELL_W-1:0] mag;
    logic [7:0]        sb;
    logic [CELL_W-1:0] word;
    mag = v[31] ? (32'd0 - v) : v;
    sb  = v[31] ? SIGN_BIT : 8'd0;
    unique case (w)
      3'd1:    word = {24'd0, mag[7:0] | sb};
      3'd2:    word = {16'd0, mag[15:8] | sb, mag[7:0]};
      3'd3:    word = {8'd0, mag[23:16] | sb, mag[15:0]};
      default: word = {mag[31:24] | sb, mag[23:0]};
    endcase
    return word;
  endfunction

  // Byte b (0 is the first sent) of a w-byte encoded word.
  function automatic logic [7:0] enc_byte(input logic [CELL_W-1:0] word,
                                          input logic [2:0] w,
                                          input logic [2:0] b);
    logic [2:0] sh;
    logic [7:0] r;
    sh = w - 3'd1 - b;
    unique case (sh[1:0])
      2'd0:    r = word[7:0];
      2'd1:    r = word[15:8];
      2'd2:    r = word[23:16];
      default: r = word[31:24];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/rrpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rrpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/rrpr_ctrl.sv]
// Sequencing state machine of the raster row packer.
`default_nettype none

module rrpr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_action,
  input  wire rrpr_pkg::sts_t sts,
  output rrpr_pkg::cmd_t     cmd,
  output logic               in_stall
);

  typedef enum logic [3:0] {
    IDLE, P1_RD, P1_EV, P2_RD, P2_EV, DECIDE, F_RD, R_RD, R_EV, EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Items are taken only while idle.
  assign in_stall = (state_r != IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      IDLE: begin
        if (in_valid) begin
          if (!in_action) begin
            cmd.load = 1'b1;
            if (sts.closes_scan) state_nxt = P1_RD;
          end else if (!sts.pending || (sts.comp && !sts.hdr) ||
                       (sts.rle && !sts.pos_zero)) begin
            state_nxt = EMIT;
          end else if (sts.rle) begin
            cmd.walk_start = 1'b1;
            state_nxt      = R_RD;
          end else begin
            state_nxt = F_RD;
          end
        end
      end
      P1_RD: state_nxt = P1_EV;
      P1_EV: begin
        cmd.p1_eval = 1'b1;
        state_nxt   = sts.scan_last ? P2_RD : P1_RD;
      end
      P2_RD: state_nxt = P2_EV;
      P2_EV: begin
        cmd.p2_eval = 1'b1;
        state_nxt   = sts.scan_last ? DECIDE : P2_RD;
      end
      DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = IDLE;
      end
      F_RD: state_nxt = EMIT;
      R_RD: state_nxt = R_EV;
      R_EV: begin
        cmd.walk_eval = 1'b1;
        state_nxt     = sts.run_stop ? EMIT : R_RD;
      end
      EMIT: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[src/rrpr_dp.sv]
// Datapath of the raster row packer: row store, scan counters and output register.
`default_nettype none

module rrpr_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rrpr_pkg::cmd_t              cmd,
  output rrpr_pkg::sts_t                   sts,
  input  wire logic                        cfg_mode,
  input  wire logic [2:0]                  cfg_eff_width,
  input  wire logic [rrpr_pkg::CELL_W-1:0] in_cell_value,
  input  wire logic                        in_last_cell,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       out_byte,
  output logic                             out_last_byte,
  output logic                             out_rle_used,
  output logic [2:0]                       out_row_width,
  output logic [2:0]                       out_file_width,
  output logic                             out_no_data
);

  localparam int CW = rrpr_pkg::CNT_W;
  localparam int AW = rrpr_pkg::ADDR_W;

  // Control state.
  logic          pending_r, pending_nxt;
  logic          comp_r, comp_nxt;
  logic          rle_r, rle_nxt;
  logic          hdr_r, hdr_nxt;
  logic [2:0]    rbw_r, rbw_nxt;
  logic [2:0]    rwm_r, rwm_nxt;
  logic [CW-1:0] cells_r, cells_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [2:0]    b_r, b_nxt;
  logic          ovalid_r, ovalid_nxt;
  // Payload state.
  logic [rrpr_pkg::CELL_W-1:0] ref_r, ref_nxt;
  logic [7:0]                  c_r, c_nxt;
  logic [CW-1:0]               pairs_r, pairs_nxt;
  logic [7:0]                  obyte_r;
  logic                        olast_r, orle_r, onodata_r;
  logic [2:0]                  orw_r, ofw_r;

  logic [rrpr_pkg::CELL_W-1:0] rd_q;
  logic [rrpr_pkg::CELL_W-1:0] word;
  logic [CW-1:0]               cells_m1;
  logic                        we, closes, first, match, scan_last, pos_w;
  logic [CW:0]                 run_sum;
  logic [CW+2:0]               lhs, rhs;
  logic [2:0]                  sig, nb_max, file_w;
  logic [7:0]                  e_byte;
  logic                        e_last;

  // Row store.
  assign we = cmd.load && !pending_r;

  rrpr_ram #(
    .WIDTH(rrpr_pkg::CELL_W),
    .DEPTH(rrpr_pkg::MAX_ROW_CELLS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(cells_r[AW-1:0]),
    .wdata(in_cell_value),
    .raddr(cur_r[AW-1:0]),
    .rdata(rd_q)
  );

  // Shared comparisons.
  assign word      = rrpr_pkg::enc_word(rd_q, rbw_r);
  assign cells_m1  = cells_r - CW'(1);
  assign scan_last = (cur_r == cells_m1);
  assign closes    = in_last_cell || (cells_r == CW'(rrpr_pkg::MAX_ROW_CELLS - 1));
  assign first     = (cur_r == run_r);
  assign match     = first || (word == ref_r && c_r != rrpr_pkg::RUN_LIMIT);
  assign run_sum   = {1'b0, run_r} + (CW+1)'(c_r);
  assign pos_w     = (b_r == rbw_r);
  assign sig       = rrpr_pkg::sig_bytes(rd_q);
  assign nb_max    = (sig > rbw_r) ? sig : rbw_r;
  assign file_w    = (rwm_r > cfg_eff_width) ? rwm_r : cfg_eff_width;
  assign lhs       = (CW+3)'(pairs_r) * (CW+3)'(rbw_r + 3'd1);
  assign rhs       = (CW+3)'(cells_r) * (CW+3)'(rbw_r);

  // Status to the controller.
  always_comb begin
    sts.pending     = pending_r;
    sts.comp        = comp_r;
    sts.rle         = rle_r;
    sts.hdr         = hdr_r;
    sts.pos_zero    = (b_r == 3'd0);
    sts.closes_scan = !pending_r && closes && cfg_mode;
    sts.scan_last   = scan_last;
    sts.run_stop    = !match || scan_last;
    sts.slot_free   = !ovalid_r || !out_stall;
  end

  // Byte for the current fetch.
  always_comb begin
    e_byte = 8'd0;
    e_last = 1'b0;
    if (comp_r && !hdr_r) begin
      e_byte = {5'd0, rbw_r};
    end else if (rle_r) begin
      if (b_r == 3'd0) begin
        e_byte = c_r;
      end else begin
        e_byte = rrpr_pkg::enc_byte(ref_r, rbw_r, b_r - 3'd1);
      end
      e_last = pos_w && ((c_r == 8'd0) || (run_sum >= {1'b0, cells_r}));
    end else begin
      e_byte = rrpr_pkg::enc_byte(word, rbw_r, b_r);
      e_last = scan_last && (b_r == rbw_r - 3'd1);
    end
  end

  // Next-state logic of the row, scan and emit counters.
  always_comb begin
    pending_nxt = pending_r;
    comp_nxt    = comp_r;
    rle_nxt     = rle_r;
    hdr_nxt     = hdr_r;
    rbw_nxt     = rbw_r;
    rwm_nxt     = rwm_r;
    cells_nxt   = cells_r;
    cur_nxt     = cur_r;
    run_nxt     = run_r;
    b_nxt       = b_r;
    ref_nxt     = ref_r;
    c_nxt       = c_r;
    pairs_nxt   = pairs_r;
    ovalid_nxt  = ovalid_r && out_stall;

    if (we) begin
      cells_nxt = cells_r + CW'(1);
      if (closes) begin
        pending_nxt = 1'b1;
        comp_nxt    = cfg_mode;
        rle_nxt     = 1'b0;
        hdr_nxt     = 1'b0;
        cur_nxt     = '0;
        run_nxt     = '0;
        b_nxt       = 3'd0;
        rbw_nxt     = cfg_mode ? 3'd1 : cfg_eff_width;
      end
    end

    // First pass: widest cell.
    if (cmd.p1_eval) begin
      rbw_nxt = nb_max;
      if (scan_last) begin
        rwm_nxt = (nb_max > rwm_r) ? nb_max : rwm_r;
        cur_nxt = '0;
      end else begin
        cur_nxt = cur_r + CW'(1);
      end
    end

    // Second pass: count runs.
    if (cmd.p2_eval) begin
      if (cur_r == '0) begin
        ref_nxt   = word;
        c_nxt     = 8'd1;
        pairs_nxt = CW'(1);
      end else if (word == ref_r && c_r != rrpr_pkg::RUN_LIMIT) begin
        c_nxt = c_r + 8'd1;
      end else begin
        pairs_nxt = pairs_r + CW'(1);
        ref_nxt   = word;
        c_nxt     = 8'd1;
      end
      cur_nxt = scan_last ? '0 : cur_r + CW'(1);
    end

    if (cmd.decide) begin
      rle_nxt = (lhs < rhs);
    end

    // Run length of the pair about to go out.
    if (cmd.walk_start) begin
      cur_nxt = run_r;
    end
    if (cmd.walk_eval && match) begin
      if (first) begin
        ref_nxt = word;
        c_nxt   = 8'd1;
      end else begin
        c_nxt = c_r + 8'd1;
      end
      if (!scan_last) cur_nxt = cur_r + CW'(1);
    end

    // Advance after a byte goes out.
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      if (pending_r) begin
        if (comp_r && !hdr_r) begin
          hdr_nxt = 1'b1;
        end else if (rle_r) begin
          if (pos_w) begin
            b_nxt   = 3'd0;
            run_nxt = run_sum[CW-1:0];
          end else begin
            b_nxt = b_r + 3'd1;
          end
        end else if (b_r == rbw_r - 3'd1) begin
          b_nxt   = 3'd0;
          cur_nxt = cur_r + CW'(1);
        end else begin
          b_nxt = b_r + 3'd1;
        end
        if (e_last) begin
          pending_nxt = 1'b0;
          cells_nxt   = '0;
          cur_nxt     = '0;
          run_nxt     = '0;
          b_nxt       = 3'd0;
          hdr_nxt     = 1'b0;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      comp_r    <= 1'b0;
      rle_r     <= 1'b0;
      hdr_r     <= 1'b0;
      rbw_r     <= 3'd1;
      rwm_r     <= 3'd0;
      cells_r   <= '0;
      cur_r     <= '0;
      run_r     <= '0;
      b_r       <= 3'd0;
      ovalid_r  <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      comp_r    <= comp_nxt;
      rle_r     <= rle_nxt;
      hdr_r     <= hdr_nxt;
      rbw_r     <= rbw_nxt;
      rwm_r     <= rwm_nxt;
      cells_r   <= cells_nxt;
      cur_r     <= cur_nxt;
      run_r     <= run_nxt;
      b_r       <= b_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  // Payload registers, including the result item.
  always_ff @(posedge clk) begin
    ref_r   <= ref_nxt;
    c_r     <= c_nxt;
    pairs_r <= pairs_nxt;
    if (cmd.emit) begin
      obyte_r   <= pending_r ? e_byte : 8'd0;
      olast_r   <= pending_r && e_last;
      orle_r    <= pending_r && rle_r;
      onodata_r <= !pending_r;
      orw_r     <= rbw_r;
      ofw_r     <= file_w;
    end
  end

  assign out_valid      = ovalid_r;
  assign out_byte       = obyte_r;
  assign out_last_byte  = olast_r;
  assign out_rle_used   = orle_r;
  assign out_row_width  = orw_r;
  assign out_file_width = ofw_r;
  assign out_no_data    = onodata_r;

  // The chosen row width stays a legal byte count.
  a_rbw_range: assert property (@(posedge clk) disable iff (!rst_n)
    rbw_r != 3'd0 && rbw_r <= 3'd4)
    else $error("row byte width out of range");

  // With no row pending, the emit cursors are parked.
  a_idle_cursors: assert property (@(posedge clk) disable iff (!rst_n)
    !pending_r |-> (!hdr_r && b_r == 3'd0 && run_r == '0))
    else $error("emit cursors not cleared");

  // The run cursor stays inside the loaded row while pairs go out.
  a_run_inside: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r && rle_r |-> run_r < cells_r)
    else $error("run cursor past end of row");

endmodule

`default_nettype wire

[src/raster_row_pack_rle.sv]
// Top level of the raster row packer: configuration registers, controller and datapath.
//
// Input items carry an action: a load stores one cell, a fetch asks for the next
// byte of the encoded row. in_last_cell on a load closes the row; so does the load
// that fills the row store. Loads while a row is still being sent are dropped.
// Only a fetch gives a result item; a fetch with no row pending returns out_no_data.
// Closing a row in compressed mode starts two passes over the stored row, each
// reading and then evaluating every cell, followed by a decide step; in_stall is
// high throughout. A fetch goes to the emit step directly, through a read of a
// stored cell first when it needs one, and for the count byte of a run through a
// walk over the run through the single row-store read port, which also reads the
// first cell past the run when the run does not end the row.
// The result sits in an output register; when the receiver holds out_stall the
// next fetch waits in the controller until the register frees.
// Reset clears the row, the running width and all control state; it sets
// compress_mode to 1 and cell_width to 4. Configuration is written through the
// APB port at byte addresses 0 and 4; pready is always high.
`default_nettype none

module raster_row_pack_rle (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [31:0] in_cell_value,
  input  wire logic        in_last_cell,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last_byte,
  output logic             out_rle_used,
  output logic [2:0]       out_row_width,
  output logic [2:0]       out_file_width,
  output logic             out_no_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic           mode_r;
  logic [2:0]     cw_r;
  logic           reg_idx;
  rrpr_pkg::cmd_t cmd;
  rrpr_pkg::sts_t sts;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      cw_r   <= 3'd4;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == rrpr_pkg::REG_MODE) mode_r <= pwdata[0];
      else cw_r <= pwdata[2:0];
    end
  end

  assign prdata = (reg_idx == rrpr_pkg::REG_WIDTH) ? {29'd0, cw_r} : {31'd0, mode_r};

  rrpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_action),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  rrpr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_mode      (mode_r),
    .cfg_eff_width (rrpr_pkg::eff_width(cw_r)),
    .in_cell_value (in_cell_value),
    .in_last_cell  (in_last_cell),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte),
    .out_rle_used  (out_rle_used),
    .out_row_width (out_row_width),
    .out_file_width(out_file_width),
    .out_no_data   (out_no_data)
  );

endmodule

`default_nettype wire
